// File: src/isaac_pkg.sv
`timescale 1ns / 1ps

package isaac_pkg;

    // pool geometry
    localparam int LOG2_POOL_SIZE = 8;
    localparam int POOL_N         = 1 << LOG2_POOL_SIZE;

    // golden ratio used to preset the mix lanes
    localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c13;

    // number of scramble rows in the lane preset (four full rounds)
    localparam int PRESET_ROWS = 32;

    typedef logic [LOG2_POOL_SIZE-1:0] pidx_t;
    typedef logic [7:0][63:0] lanes_t;

    // command from the sequencer to the mix lane unit
    typedef struct packed {
        logic        preset;
        logic        add_en;
        logic [2:0]  add_lane;
        logic [63:0] add_val;
        logic        row_en;
        logic [2:0]  row;
    } mix_cmd_t;

    // shift amount of each scramble row; even rows shift right, odd rows left
    function automatic logic [5:0] row_shift(input logic [2:0] r);
        logic [5:0] amt;
        case (r)
            3'd0:    amt = 6'd9;
            3'd1:    amt = 6'd9;
            3'd2:    amt = 6'd23;
            3'd3:    amt = 6'd15;
            3'd4:    amt = 6'd14;
            3'd5:    amt = 6'd20;
            3'd6:    amt = 6'd17;
            default: amt = 6'd14;
        endcase
        return amt;
    endfunction

endpackage

// File: src/isaac64_random_generator.sv
`timescale 1ns / 1ps

// ISAAC-64 random word generator with built-in seeding.
// Input channel s_*: s_op = 0 carries the next seed word in s_seed_value,
// s_op = 1 asks for the next random word. A full seeding is POOL_N seed
// beats in order; seed beats give no result. Each generate beat gives one
// result beat on m_*: the new word, m_valid_res and m_batch_end. Before
// seeding completes a generate beat returns zero with m_valid_res low.
// Each beat is worked through by the sequencer over the pool (one write
// port, one read port) and the shared scramble row unit (one row per cycle):
//   generate: four pool reads, one pool write, the result load
//   seed word: the lane add, after the lane preset on the first word, plus
//   at the end of each group of eight, 8 scramble rows and 8 pool writes,
//   plus on the last word the second pass: read, add, scramble, store per group
// s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) clears the sequencer, the counters and
// the accumulators and marks the pool unseeded; the pool needs no clearing.
// A stalled receiver holds the result in the output register; one more
// finished generate beat waits in the sequencer until the register frees.
module isaac64_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_random_word,
    output logic        m_valid_res,
    output logic        m_batch_end
);

    localparam int PW = isaac_pkg::LOG2_POOL_SIZE;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_PRESET = 14'b00000000000010,
        S_ADD    = 14'b00000000000100,
        S_SCR    = 14'b00000000001000,
        S_WR     = 14'b00000000010000,
        S_P2RD   = 14'b00000000100000,
        S_G0     = 14'b00000001000000,
        S_G1     = 14'b00000010000000,
        S_G2     = 14'b00000100000000,
        S_G3     = 14'b00001000000000,
        S_G4     = 14'b00010000000000,
        S_G5     = 14'b00100000000000,
        S_OUT    = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] c_reg, c_next;
    isaac_pkg::pidx_t step_reg, step_next;
    isaac_pkg::pidx_t seed_cnt_reg, seed_cnt_next;
    isaac_pkg::pidx_t base_reg, base_next;
    logic        ready_reg, ready_next;
    logic        pass2_reg, pass2_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] seed_val_reg, seed_val_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] res_word_reg, res_word_next;
    logic        res_vr_reg, res_vr_next;
    logic        res_be_reg, res_be_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_word_reg, m_word_next;
    logic        m_vr_reg, m_vr_next;
    logic        m_be_reg, m_be_next;

    logic              pool_wr_en;
    isaac_pkg::pidx_t  pool_wr_addr;
    logic [63:0]       pool_wr_data;
    isaac_pkg::pidx_t  pool_rd_addr;
    logic [63:0]       pool_rd_data;

    isaac_pkg::mix_cmd_t mix_cmd;
    isaac_pkg::lanes_t   lanes;

    logic        in_beat;
    logic [63:0] mixed;
    logic [63:0] y_sum;

    isaac_ram #(
        .WIDTH (64),
        .DEPTH (isaac_pkg::POOL_N)
    ) u_pool (
        .aclk    (aclk),
        .wr_en   (pool_wr_en),
        .wr_addr (pool_wr_addr),
        .wr_data (pool_wr_data),
        .rd_addr (pool_rd_addr),
        .rd_data (pool_rd_data)
    );

    isaac_mix u_mix (
        .aclk  (aclk),
        .cmd   (mix_cmd),
        .lanes (lanes)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign in_beat = s_valid && s_ready;

    // accumulator mix chosen by step mod 4
    always_comb begin
        case (step_reg[1:0])
            2'd0:    mixed = ~(a_reg ^ (a_reg << 21));
            2'd1:    mixed = a_reg ^ (a_reg >> 5);
            2'd2:    mixed = a_reg ^ (a_reg << 12);
            default: mixed = a_reg ^ (a_reg >> 33);
        endcase
    end

    assign y_sum = pool_rd_data + a_reg + b_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        step_next     = step_reg;
        seed_cnt_next = seed_cnt_reg;
        base_next     = base_reg;
        ready_next    = ready_reg;
        pass2_next    = pass2_reg;
        cnt_next      = cnt_reg;
        seed_val_next = seed_val_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        res_word_next = res_word_reg;
        res_vr_next   = res_vr_reg;
        res_be_next   = res_be_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;
        m_vr_next     = m_vr_reg;
        m_be_next     = m_be_reg;

        pool_wr_en    = 1'b0;
        pool_wr_addr  = step_reg;
        pool_wr_data  = y_sum;
        pool_rd_addr  = step_reg;

        mix_cmd          = '0;
        mix_cmd.add_lane = seed_cnt_reg[2:0];
        mix_cmd.add_val  = seed_val_reg;
        mix_cmd.row      = cnt_reg[2:0];

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    if (s_op) begin
                        if (ready_reg) begin
                            state_next = S_G0;
                        end else begin
                            res_word_next = '0;
                            res_vr_next   = 1'b0;
                            res_be_next   = 1'b0;
                            state_next    = S_OUT;
                        end
                    end else begin
                        seed_val_next = s_seed_value;
                        if (seed_cnt_reg == '0) begin
                            a_next         = '0;
                            b_next         = '0;
                            c_next         = '0;
                            step_next      = '0;
                            ready_next     = 1'b0;
                            cnt_next       = '0;
                            mix_cmd.preset = 1'b1;
                            state_next     = S_PRESET;
                        end else begin
                            state_next = S_ADD;
                        end
                    end
                end
            end

            // four scramble rounds over the golden ratio
            S_PRESET: begin
                mix_cmd.row_en = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(isaac_pkg::PRESET_ROWS - 1)) begin
                    state_next = S_ADD;
                end
            end

            // add the seed word to its lane
            S_ADD: begin
                mix_cmd.add_en = 1'b1;
                seed_cnt_next  = seed_cnt_reg + 1'b1;
                if (seed_cnt_reg[2:0] == 3'd7) begin
                    base_next  = seed_cnt_reg & ~PW'(7);
                    cnt_next   = '0;
                    state_next = S_SCR;
                end else begin
                    state_next = S_IDLE;
                end
            end

            S_SCR: begin
                mix_cmd.row_en = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7) begin
                    cnt_next   = '0;
                    state_next = S_WR;
                end
            end

            // store the eight lanes into the group
            S_WR: begin
                pool_wr_en   = 1'b1;
                pool_wr_addr = base_reg | PW'(cnt_reg[2:0]);
                pool_wr_data = lanes[cnt_reg[2:0]];
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7) begin
                    cnt_next = '0;
                    if (pass2_reg) begin
                        if (base_reg == PW'(isaac_pkg::POOL_N - 8)) begin
                            ready_next = 1'b1;
                            pass2_next = 1'b0;
                            state_next = S_IDLE;
                        end else begin
                            base_next  = base_reg + PW'(8);
                            state_next = S_P2RD;
                        end
                    end else if (seed_cnt_reg == '0) begin
                        pass2_next = 1'b1;
                        base_next  = '0;
                        state_next = S_P2RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // second pass: read a group and add it to the lanes
            S_P2RD: begin
                pool_rd_addr     = base_reg | PW'(cnt_reg[2:0]);
                mix_cmd.add_en   = (cnt_reg != '0);
                mix_cmd.add_lane = cnt_reg[2:0] - 3'd1;
                mix_cmd.add_val  = pool_rd_data;
                cnt_next         = cnt_reg + 6'd1;
                if (cnt_reg == 6'd8) begin
                    cnt_next   = '0;
                    state_next = S_SCR;
                end
            end

            S_G0: begin
                pool_rd_addr = step_reg;
                if (step_reg == '0) begin
                    c_next = c_reg + 64'd1;
                end
                state_next = S_G1;
            end

            S_G1: begin
                x_next       = pool_rd_data;
                pool_rd_addr = step_reg + PW'(isaac_pkg::POOL_N / 2);
                if (step_reg == '0) begin
                    b_next = b_reg + c_reg;
                end
                state_next = S_G2;
            end

            S_G2: begin
                a_next       = mixed + pool_rd_data;
                pool_rd_addr = x_reg[3 +: PW];
                state_next   = S_G3;
            end

            S_G3: begin
                pool_wr_en   = 1'b1;
                pool_wr_addr = step_reg;
                pool_wr_data = y_sum;
                y_next       = y_sum;
                state_next   = S_G4;
            end

            S_G4: begin
                pool_rd_addr = y_reg[PW + 3 +: PW];
                state_next   = S_G5;
            end

            S_G5: begin
                b_next        = pool_rd_data + x_reg;
                res_word_next = pool_rd_data + x_reg;
                res_vr_next   = 1'b1;
                res_be_next   = (step_reg == PW'(isaac_pkg::POOL_N - 1));
                step_next     = step_reg + 1'b1;
                state_next    = S_OUT;
            end

            // hand the result to the output register
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_word_reg;
                    m_vr_next    = res_vr_reg;
                    m_be_next    = res_be_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            step_reg     <= '0;
            seed_cnt_reg <= '0;
            ready_reg    <= 1'b0;
            pass2_reg    <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            c_reg        <= c_next;
            step_reg     <= step_next;
            seed_cnt_reg <= seed_cnt_next;
            ready_reg    <= ready_next;
            pass2_reg    <= pass2_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        seed_val_reg <= seed_val_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        res_word_reg <= res_word_next;
        res_vr_reg   <= res_vr_next;
        res_be_reg   <= res_be_next;
        m_word_reg   <= m_word_next;
        m_vr_reg     <= m_vr_next;
        m_be_reg     <= m_be_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;
    assign m_valid_res   = m_vr_reg;
    assign m_batch_end   = m_be_reg;

    // the step index advances by one after each finished step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_G5) |=> (step_reg == $past(step_reg) + 1'b1))
        else $error("step index did not advance");

    // the pool is written only by group stores and generate steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        pool_wr_en |-> (state_reg == S_WR || state_reg == S_G3))
        else $error("pool written outside a store state");

    // the pool becomes ready only at the end of a group store
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ready_reg) |-> $past(state_reg == S_WR && pass2_reg))
        else $error("pool marked ready outside the second pass");

    // a generate step is started only on a seeded pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_G0) |-> ready_reg)
        else $error("generate step on unseeded pool");

endmodule

// File: src/isaac_ram.sv
`timescale 1ns / 1ps

module isaac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/isaac_mix.sv
`timescale 1ns / 1ps

module isaac_mix (
    input  logic                aclk,
    input  isaac_pkg::mix_cmd_t cmd,
    output isaac_pkg::lanes_t   lanes
);

    isaac_pkg::lanes_t lanes_reg;
    isaac_pkg::lanes_t lanes_next;

    // golden-ratio preset, else a lane add, else one scramble row per cycle; lane indexes rotate with the row number
    always_comb begin
        logic [2:0]  i4;
        logic [2:0]  i5;
        logic [2:0]  i7;
        logic [5:0]  amt;
        logic [63:0] nr;
        logic [63:0] sh;
        i4 = cmd.row + 3'd4;
        i5 = cmd.row + 3'd5;
        i7 = cmd.row + 3'd7;
        amt = isaac_pkg::row_shift(cmd.row);
        nr = lanes_reg[cmd.row] - lanes_reg[i4];
        sh = cmd.row[0] ? (lanes_reg[i7] << amt) : (lanes_reg[i7] >> amt);
        lanes_next = lanes_reg;
        if (cmd.preset) begin
            for (int k = 0; k < 8; k++) begin
                lanes_next[k] = isaac_pkg::GOLDEN_RATIO;
            end
        end else if (cmd.add_en) begin
            lanes_next[cmd.add_lane] = lanes_reg[cmd.add_lane] + cmd.add_val;
        end else if (cmd.row_en) begin
            lanes_next[cmd.row] = nr;
            lanes_next[i5]      = lanes_reg[i5] ^ sh;
            lanes_next[i7]      = lanes_reg[i7] + nr;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
    end

    assign lanes = lanes_reg;

endmodule

// File: tb/isaac64_random_generator_tb.sv
`timescale 1ns / 1ps

module isaac64_random_generator_tb;

    typedef enum logic {OP_SEED = 1'b0, OP_GEN = 1'b1} op_t;

    typedef struct {
        logic [63:0] word;
        logic        seeded;
        logic        last_step;
    } word_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [63:0] s_seed_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_random_word;
    logic        m_valid_res;
    logic        m_batch_end;

    // predicted generator state
    logic [63:0] pool_q [isaac_pkg::POOL_N];
    logic [63:0] lane_q [8];
    logic [63:0] acc_a, acc_b, batch_cnt;
    isaac_pkg::pidx_t step_idx, seed_pos;
    logic        seeded;

    word_res_t   pending_words[$];
    int          fail_cnt;
    int          stall_left;
    int          hold_cycles;
    bit          quiet;

    isaac64_random_generator dut (.*);

    // clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // one round of the lane scramble
    task automatic scramble_lanes();
        lane_q[0] -= lane_q[4]; lane_q[5] ^= lane_q[7] >> 9;  lane_q[7] += lane_q[0];
        lane_q[1] -= lane_q[5]; lane_q[6] ^= lane_q[0] << 9;  lane_q[0] += lane_q[1];
        lane_q[2] -= lane_q[6]; lane_q[7] ^= lane_q[1] >> 23; lane_q[1] += lane_q[2];
        lane_q[3] -= lane_q[7]; lane_q[0] ^= lane_q[2] << 15; lane_q[2] += lane_q[3];
        lane_q[4] -= lane_q[0]; lane_q[1] ^= lane_q[3] >> 14; lane_q[3] += lane_q[4];
        lane_q[5] -= lane_q[1]; lane_q[2] ^= lane_q[4] << 20; lane_q[4] += lane_q[5];
        lane_q[6] -= lane_q[2]; lane_q[3] ^= lane_q[5] >> 17; lane_q[5] += lane_q[6];
        lane_q[7] -= lane_q[3]; lane_q[4] ^= lane_q[6] << 14; lane_q[6] += lane_q[7];
    endtask

    // absorb one seed word, second pass after the last one
    task automatic absorb_seed(input logic [63:0] value);
        int lane;
        lane = int'(seed_pos) % 8;
        if (seed_pos == '0) begin
            acc_a = '0;
            acc_b = '0;
            batch_cnt = '0;
            step_idx = '0;
            seeded = 1'b0;
            for (int k = 0; k < 8; k++) lane_q[k] = isaac_pkg::GOLDEN_RATIO;
            repeat (4) scramble_lanes();
        end
        lane_q[lane] += value;
        if (lane == 7) begin
            scramble_lanes();
            for (int k = 0; k < 8; k++) pool_q[int'(seed_pos) - 7 + k] = lane_q[k];
        end
        if (seed_pos == isaac_pkg::pidx_t'(isaac_pkg::POOL_N - 1)) begin
            for (int g = 0; g < isaac_pkg::POOL_N; g += 8) begin
                for (int k = 0; k < 8; k++) lane_q[k] += pool_q[g + k];
                scramble_lanes();
                for (int k = 0; k < 8; k++) pool_q[g + k] = lane_q[k];
            end
            seeded = 1'b1;
        end
        seed_pos = seed_pos + 1'b1;
    endtask

    // one generator step
    function automatic word_res_t next_word();
        word_res_t   r;
        logic [63:0] mixed, x, y;
        isaac_pkg::pidx_t i;
        i = step_idx;
        r = '{64'd0, 1'b0, 1'b0};
        if (!seeded) return r;
        if (i == '0) begin
            batch_cnt += 1;
            acc_b += batch_cnt;
        end
        case (i[1:0])
            2'd0:    mixed = ~(acc_a ^ (acc_a << 21));
            2'd1:    mixed = acc_a ^ (acc_a >> 5);
            2'd2:    mixed = acc_a ^ (acc_a << 12);
            default: mixed = acc_a ^ (acc_a >> 33);
        endcase
        x = pool_q[i];
        acc_a = mixed + pool_q[isaac_pkg::pidx_t'(i + isaac_pkg::POOL_N / 2)];
        y = pool_q[isaac_pkg::pidx_t'(x >> 3)] + acc_a + acc_b;
        pool_q[i] = y;
        acc_b = pool_q[isaac_pkg::pidx_t'((y >> isaac_pkg::LOG2_POOL_SIZE) >> 3)] + x;
        step_idx = i + 1'b1;
        r.word = acc_b;
        r.seeded = 1'b1;
        r.last_step = (i == isaac_pkg::pidx_t'(isaac_pkg::POOL_N - 1));
        return r;
    endfunction

    // offer one beat, predict on acceptance
    task automatic send_item(input op_t op, input logic [63:0] value);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_seed_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_SEED) absorb_seed(value);
        else pending_words.push_back(next_word());
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic seed_range(input int count);
        repeat (count) send_item(OP_SEED, rand64());
    endtask

    task automatic gen_words(input int count);
        repeat (count) send_item(OP_GEN, rand64());
    endtask

    // generate requests before any seeding
    task automatic test_unseeded();
        send_item(OP_GEN, '0);
        send_item(OP_GEN, '1);
        gen_words(2);
    endtask

    // full seeding with extreme words, then past one pool pass
    task automatic test_seed_extremes();
        send_item(OP_SEED, '0);
        send_item(OP_SEED, '1);
        send_item(OP_SEED, 64'h8000_0000_0000_0000);
        send_item(OP_SEED, 64'd1);
        send_item(OP_SEED, 64'h5555_5555_5555_5555);
        send_item(OP_SEED, 64'haaaa_aaaa_aaaa_aaaa);
        seed_range(isaac_pkg::POOL_N - 6);
        gen_words(isaac_pkg::POOL_N + 40);
    endtask

    // reseed broken off by generate requests, then completed
    task automatic test_reseed_partial();
        seed_range(100);
        gen_words(3);
        seed_range(isaac_pkg::POOL_N - 100);
        gen_words(50);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_cycles = 300;
        gen_words(40);
    endtask

    // random seeding rounds and long generate runs
    task automatic test_random();
        seed_range(isaac_pkg::POOL_N);
        gen_words(100);
        seed_range($urandom_range(1, 20));
        gen_words(5);
        seed_range(seed_pos == '0 ? 0 : isaac_pkg::POOL_N - int'(seed_pos));
        gen_words(100);
        quiet = 1'b1;
        gen_words(150);
    endtask

    // receiver ready with random stall bursts and an occasional long hold
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest predicted word
    always @(posedge aclk) begin
        word_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t unexpected result beat: word %h valid %b end %b", $time,
                    m_random_word, m_valid_res, m_batch_end);
                fail_cnt++;
            end else begin
                e = pending_words.pop_front();
                if (m_random_word !== e.word) begin
                    $display("%0t random_word expected %h actual %h", $time, e.word,
                        m_random_word);
                    fail_cnt++;
                end
                if (m_valid_res !== e.seeded) begin
                    $display("%0t valid_res expected %b actual %b", $time, e.seeded,
                        m_valid_res);
                    fail_cnt++;
                end
                if (m_batch_end !== e.last_step) begin
                    $display("%0t batch_end expected %b actual %b", $time, e.last_step,
                        m_batch_end);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_op         <= OP_SEED;
        s_seed_value <= '0;
        m_ready      <= 1'b0;
        fail_cnt = 0;
        stall_left = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        acc_a = '0;
        acc_b = '0;
        batch_cnt = '0;
        step_idx = '0;
        seed_pos = '0;
        seeded = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unseeded();
        test_seed_extremes();
        test_reseed_partial();
        test_backpressure();
        test_random();

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (fail_cnt == 0 && pending_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
